/* hw/rtl/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_LEAD     = 2'd1;
    localparam logic [1:0] ERR_CONT     = 2'd2;
    localparam logic [1:0] ERR_FULL     = 2'd3;

    localparam logic [7:0]  LEAD_MIN    = 8'hC2;
    localparam logic [7:0]  LEAD_MAX    = 8'hF4;
    localparam logic [7:0]  LEAD_3B     = 8'hE0;
    localparam logic [7:0]  LEAD_4B     = 8'hF0;
    localparam logic [7:0]  LEAD_ED     = 8'hED;
    localparam logic [7:0]  ED_MAX      = 8'h9F;
    localparam logic [7:0]  F4_MAX      = 8'h8F;
    localparam logic [7:0]  E0_MIN      = 8'hA0;
    localparam logic [7:0]  F0_MIN      = 8'h90;
    localparam logic [15:0] HI_SURR     = 16'hD800;
    localparam logic [15:0] LO_SURR     = 16'hDC00;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;
    localparam logic [15:0] CAP_RESET   = 16'hFFFF;

    typedef struct packed {
        logic [15:0] code_unit;
        logic        last;
        logic [1:0]  error_code;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

/* hw/rtl/u8u16_if.sv */
// ----------------------------------------------------------------------------
// u8u16_if
// Valid/ready channels: UTF-8 byte beats in, UTF-16 result beats out.
// ----------------------------------------------------------------------------
interface u8u16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface u8u16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last;
    logic [1:0]  error_code;

    modport source (output valid, output code_unit, output last, output error_code,
                    input ready);
    modport sink   (input valid, input code_unit, input last, input error_code,
                    output ready);
endinterface

/* hw/rtl/u8u16_decode.sv */
// ----------------------------------------------------------------------------
// u8u16_decode
// Byte register plus single-pass UTF-8 validate/decode; pushes 0-2 results.
// ----------------------------------------------------------------------------
module u8u16_decode (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [15:0]           capacity,
    input  logic                  byte_valid,
    input  logic [7:0]            byte_data,
    output logic                  byte_ready,
    input  logic                  space_ok,
    output u8u16_pkg::push_t      push
);
    import u8u16_pkg::*;

    logic        bv_reg;
    logic [7:0]  b_reg;
    logic        advance;

    logic [1:0]  bytes_left_reg,    bytes_left_next;
    logic [20:0] partial_point_reg, partial_point_next;
    logic [7:0]  lead_held_reg,     lead_held_next;
    logic        first_follow_reg,  first_follow_next;
    logic [15:0] units_written_reg, units_written_next;
    logic        discarding_reg,    discarding_next;

    logic [15:0] limit;
    logic [16:0] units_plus2;
    logic        cont_ok;
    logic [20:0] pp_shift;
    logic [1:0]  bl_dec;
    logic [20:0] supp;
    logic        fail_en;
    logic [1:0]  fail_code;

    assign advance    = bv_reg && space_ok;
    assign byte_ready = !bv_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bv_reg <= 1'b0;
        end
        else if (byte_ready)
        begin
            bv_reg <= byte_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_ready && byte_valid)
        begin
            b_reg <= byte_data;
        end
    end

    assign limit       = (capacity == 16'd0) ? 16'd0 : capacity - 16'd1;
    assign units_plus2 = {1'b0, units_written_reg} + 17'd2;
    assign pp_shift    = {partial_point_reg[14:0], b_reg[5:0]};
    assign bl_dec      = bytes_left_reg - 2'd1;
    assign supp        = pp_shift - SUPP_BASE;

    always_comb
    begin
        cont_ok = (b_reg[7:6] == 2'b10);
        if (first_follow_reg)
        begin
            if (lead_held_reg == LEAD_3B && b_reg < E0_MIN) cont_ok = 1'b0;
            if (lead_held_reg == LEAD_ED && b_reg > ED_MAX) cont_ok = 1'b0;
            if (lead_held_reg == LEAD_4B && b_reg < F0_MIN) cont_ok = 1'b0;
            if (lead_held_reg == LEAD_MAX && b_reg > F4_MAX) cont_ok = 1'b0;
        end
    end

    always_comb
    begin
        bytes_left_next    = bytes_left_reg;
        partial_point_next = partial_point_reg;
        lead_held_next     = lead_held_reg;
        first_follow_next  = first_follow_reg;
        units_written_next = units_written_reg;
        discarding_next    = discarding_reg;
        fail_en            = 1'b0;
        fail_code          = ERR_NONE;
        push               = '0;

        if (advance)
        begin
            if (discarding_reg)
            begin
                if (b_reg == 8'd0)
                begin
                    discarding_next = 1'b0;
                end
            end
            else if (bytes_left_reg == 2'd0)
            begin
                if (b_reg == 8'd0)
                begin
                    bytes_left_next    = 2'd0;
                    partial_point_next = '0;
                    lead_held_next     = '0;
                    first_follow_next  = 1'b0;
                    units_written_next = '0;
                    push.cnt           = 2'd1;
                    push.r0.last       = 1'b1;
                end
                else if (units_written_reg >= limit)
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_FULL;
                end
                else if (!b_reg[7])
                begin
                    units_written_next = units_written_reg + 16'd1;
                    push.cnt           = 2'd1;
                    push.r0.code_unit  = {8'd0, b_reg};
                end
                else if (b_reg < LEAD_MIN || b_reg > LEAD_MAX)
                begin
                    fail_en   = 1'b1;
                    fail_code = ERR_LEAD;
                end
                else
                begin
                    lead_held_next    = b_reg;
                    first_follow_next = 1'b1;
                    if (b_reg < LEAD_3B)
                    begin
                        bytes_left_next    = 2'd1;
                        partial_point_next = {16'd0, b_reg[4:0]};
                    end
                    else if (b_reg < LEAD_4B)
                    begin
                        bytes_left_next    = 2'd2;
                        partial_point_next = {17'd0, b_reg[3:0]};
                    end
                    else
                    begin
                        bytes_left_next    = 2'd3;
                        partial_point_next = {18'd0, b_reg[2:0]};
                    end
                end
            end
            else if (!cont_ok)
            begin
                fail_en   = 1'b1;
                fail_code = ERR_CONT;
            end
            else
            begin
                first_follow_next  = 1'b0;
                partial_point_next = pp_shift;
                bytes_left_next    = bl_dec;
                if (bl_dec == 2'd0)
                begin
                    if (lead_held_reg < LEAD_4B)
                    begin
                        units_written_next = units_written_reg + 16'd1;
                        partial_point_next = '0;
                        lead_held_next     = '0;
                        push.cnt           = 2'd1;
                        push.r0.code_unit  = pp_shift[15:0];
                    end
                    else if (units_plus2 > {1'b0, limit})
                    begin
                        fail_en   = 1'b1;
                        fail_code = ERR_FULL;
                    end
                    else
                    begin
                        units_written_next = units_plus2[15:0];
                        partial_point_next = '0;
                        lead_held_next     = '0;
                        push.cnt           = 2'd2;
                        push.r0.code_unit  = HI_SURR | {6'd0, supp[19:10]};
                        push.r1.code_unit  = LO_SURR | {6'd0, supp[9:0]};
                    end
                end
            end

            if (fail_en)
            begin
                bytes_left_next     = 2'd0;
                partial_point_next  = '0;
                lead_held_next      = '0;
                first_follow_next   = 1'b0;
                units_written_next  = '0;
                discarding_next     = (b_reg != 8'd0);
                push                = '0;
                push.cnt            = 2'd1;
                push.r0.last        = 1'b1;
                push.r0.error_code  = fail_code;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg    <= '0;
            partial_point_reg <= '0;
            lead_held_reg     <= '0;
            first_follow_reg  <= 1'b0;
            units_written_reg <= '0;
            discarding_reg    <= 1'b0;
        end
        else
        begin
            bytes_left_reg    <= bytes_left_next;
            partial_point_reg <= partial_point_next;
            lead_held_reg     <= lead_held_next;
            first_follow_reg  <= first_follow_next;
            units_written_reg <= units_written_next;
            discarding_reg    <= discarding_next;
        end
    end

endmodule

/* hw/rtl/u8u16_outq.sv */
// ----------------------------------------------------------------------------
// u8u16_outq
// Four-entry result queue; takes up to two results a cycle, sends one beat.
// ----------------------------------------------------------------------------
module u8u16_outq (
    input  logic                  clk,
    input  logic                  rst_n,
    input  u8u16_pkg::push_t      push,
    output logic                  space_ok,
    output logic                  out_valid,
    input  logic                  out_ready,
    output u8u16_pkg::result_t    out_data
);
    import u8u16_pkg::*;

    result_t    q_reg [4];
    logic [1:0] wptr_reg;
    logic [1:0] rptr_reg;
    logic [2:0] count_reg;
    logic       pop;

    assign out_valid = (count_reg != 3'd0);
    assign out_data  = q_reg[rptr_reg];
    assign pop       = out_valid && out_ready;
    assign space_ok  = (count_reg <= 3'd2);

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
        begin
            q_reg[wptr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2)
        begin
            q_reg[wptr_reg + 2'd1] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_reg + push.cnt;
            rptr_reg  <= rptr_reg + {1'b0, pop};
            count_reg <= count_reg + {1'b0, push.cnt} - {2'd0, pop};
        end
    end

endmodule

/* hw/rtl/utf8_to_utf16_transcoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Strict streaming UTF-8 to UTF-16 transcoder with output capacity check.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte beat per cycle while the result queue has room. Each
// byte sits in an input register while a single pass of decode logic
// validates it and produces zero, one or two UTF-16 units into a four-entry
// result queue, from which they are sent as result beats. Input stalls
// while the queue holds three or more results, whether or not the sink is
// draining. Write cfg_wr_data (capacity, terminator included) between strings.
module utf8_to_utf16_transcoder (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_wr_en,
    input  logic [15:0]    cfg_wr_data,
    u8u16_in_if.sink       in_ch,
    u8u16_out_if.source    out_ch
);
    import u8u16_pkg::*;

    logic [15:0] capacity_reg;
    push_t       push;
    logic        space_ok;
    result_t     res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            capacity_reg <= cfg_wr_data;
        end
    end

    u8u16_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .capacity   (capacity_reg),
        .byte_valid (in_ch.valid),
        .byte_data  (in_ch.in_byte),
        .byte_ready (in_ch.ready),
        .space_ok   (space_ok),
        .push       (push)
    );

    u8u16_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space_ok  (space_ok),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (res)
    );

    assign out_ch.code_unit  = res.code_unit;
    assign out_ch.last       = res.last;
    assign out_ch.error_code = res.error_code;

endmodule

/* verif/u8u16_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8u16_checker
// Passive scoreboard for the UTF-8 to UTF-16 transcoder. It follows the
// capacity writes and every accepted byte beat, keeps its own copy of the
// decode state, and queues the UTF-16 results each byte should produce.
// Every accepted result beat is matched field by field against the oldest
// queued result. Reports the failure count and the number of results still
// owed.
// ----------------------------------------------------------------------------
module u8u16_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    u8u16_in_if         in_ch,
    u8u16_out_if        out_ch,
    output int          fail_count,
    output int          outstanding
);
    import u8u16_pkg::*;

    logic [15:0] capacity;
    logic [1:0]  follow_cnt;
    logic [20:0] code_point;
    logic [7:0]  seq_lead;
    logic        second_byte;
    int          units_used;
    logic        skipping;
    result_t     owed_units[$];
    int          mismatches;

    function automatic result_t mk_result(logic [15:0] unit, logic last, logic [1:0] err);
        result_t r;
        r.code_unit  = unit;
        r.last       = last;
        r.error_code = err;
        return r;
    endfunction

    // a zero capacity behaves like one: no character fits
    function automatic int unit_limit();
        return (capacity == 16'd0) ? 0 : int'(capacity) - 1;
    endfunction

    task automatic clear_string();
        follow_cnt  = 2'd0;
        code_point  = '0;
        seq_lead    = 8'h00;
        second_byte = 1'b0;
        units_used  = 0;
    endtask

    task automatic end_with_error(logic [1:0] err, logic [7:0] b);
        clear_string();
        skipping = (b != 8'h00);
        owed_units.push_back(mk_result(16'h0000, 1'b1, err));
    endtask

    task automatic decode_byte(logic [7:0] b);
        logic        ok;
        logic [20:0] supp;
        if (skipping)
        begin
            if (b == 8'h00)
                skipping = 1'b0;
        end
        else if (follow_cnt == 2'd0)
        begin
            if (b == 8'h00)
            begin
                clear_string();
                owed_units.push_back(mk_result(16'h0000, 1'b1, ERR_NONE));
            end
            else if (units_used >= unit_limit())
                end_with_error(ERR_FULL, b);
            else if (b < 8'h80)
            begin
                units_used++;
                owed_units.push_back(mk_result({8'h00, b}, 1'b0, ERR_NONE));
            end
            else if (b < LEAD_MIN || b > LEAD_MAX)
                end_with_error(ERR_LEAD, b);
            else
            begin
                seq_lead    = b;
                second_byte = 1'b1;
                if (b < LEAD_3B)
                begin
                    follow_cnt = 2'd1;
                    code_point = {16'h0000, b[4:0]};
                end
                else if (b < LEAD_4B)
                begin
                    follow_cnt = 2'd2;
                    code_point = {17'h00000, b[3:0]};
                end
                else
                begin
                    follow_cnt = 2'd3;
                    code_point = {18'h00000, b[2:0]};
                end
            end
        end
        else
        begin
            ok = (b[7:6] == 2'b10);
            if (ok && second_byte)
            begin
                if (seq_lead == LEAD_3B && b < E0_MIN)
                    ok = 1'b0;
                if (seq_lead == LEAD_ED && b > ED_MAX)
                    ok = 1'b0;
                if (seq_lead == LEAD_4B && b < F0_MIN)
                    ok = 1'b0;
                if (seq_lead == LEAD_MAX && b > F4_MAX)
                    ok = 1'b0;
            end
            if (!ok)
                end_with_error(ERR_CONT, b);
            else
            begin
                second_byte = 1'b0;
                code_point  = {code_point[14:0], b[5:0]};
                follow_cnt  = follow_cnt - 2'd1;
                if (follow_cnt == 2'd0)
                begin
                    if (seq_lead < LEAD_4B)
                    begin
                        units_used++;
                        owed_units.push_back(mk_result(code_point[15:0], 1'b0, ERR_NONE));
                        code_point = '0;
                        seq_lead   = 8'h00;
                    end
                    else if (units_used + 2 > unit_limit())
                        end_with_error(ERR_FULL, b);
                    else
                    begin
                        supp = code_point - SUPP_BASE;
                        units_used += 2;
                        owed_units.push_back(mk_result(HI_SURR | {6'h00, supp[19:10]},
                                                       1'b0, ERR_NONE));
                        owed_units.push_back(mk_result(LO_SURR | {6'h00, supp[9:0]},
                                                       1'b0, ERR_NONE));
                        code_point = '0;
                        seq_lead   = 8'h00;
                    end
                end
            end
        end
    endtask

    task automatic match_result();
        result_t seen;
        result_t want;
        seen = mk_result(out_ch.code_unit, out_ch.last, out_ch.error_code);
        if (owed_units.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result beat with nothing owed: unit %h last %b err %0d",
                         $realtime, seen.code_unit, seen.last, seen.error_code);
        end
        else
        begin
            want = owed_units.pop_front();
            if (seen.code_unit !== want.code_unit || seen.last !== want.last ||
                seen.error_code !== want.error_code)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: expected %h last %b err %0d, got %h last %b err %0d",
                             $realtime, want.code_unit, want.last, want.error_code,
                             seen.code_unit, seen.last, seen.error_code);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity = CAP_RESET;
            clear_string();
            skipping = 1'b0;
            owed_units.delete();
            mismatches = 0;
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wr_en)
                capacity = cfg_wr_data;
            if (in_ch.valid && in_ch.ready)
                decode_byte(in_ch.in_byte);
            if (out_ch.valid && out_ch.ready)
                match_result();
            fail_count  <= mismatches;
            outstanding <= owed_units.size();
        end
    end

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Top level for the UTF-8 to UTF-16 transcoder. Drives a directed set of
// boundary strings and then random strings, mostly well-formed UTF-8 with
// occasional broken sequences and noise, across a series of output capacities.
// Both channels idle at random per beat. Checking is done by u8u16_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import u8u16_pkg::*;

    localparam int IDLE_LIMIT    = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 210;
    localparam int NUM_PHASES    = 9;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    int          fail_count;
    int          outstanding;
    bit          in_calm;
    bit          out_calm;
    logic [7:0]  utf8_bytes[$];

    u8u16_in_if  in_ch();
    u8u16_out_if out_ch();

    utf8_to_utf16_transcoder uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    u8u16_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 19);
    endfunction

    // result sink with random stalls
    initial
    begin
        int n;
        out_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            n = draw_gap(out_calm);
            if (n > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_ch.valid && out_ch.ready));
        end
    end

    task automatic send_byte(logic [7:0] b);
        int n;
        n = draw_gap(in_calm);
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do
            @(posedge clk);
        while (!(in_ch.valid && in_ch.ready));
    endtask

    task automatic send_string();
        foreach (utf8_bytes[i])
            send_byte(utf8_bytes[i]);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_capacity(logic [15:0] cap);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [20:0] draw_point(int kind);
        logic [20:0] lo;
        logic [20:0] hi;
        logic [20:0] cp;
        case (kind)
            0:
            begin
                lo = 21'h1;
                hi = 21'h7F;
            end
            1:
            begin
                lo = 21'h80;
                hi = 21'h7FF;
            end
            2:
            begin
                lo = 21'h800;
                hi = 21'hFFFF;
            end
            default:
            begin
                lo = 21'h10000;
                hi = 21'h10FFFF;
            end
        endcase
        if ($urandom_range(0, 3) == 0)
            cp = $urandom_range(0, 1) ? hi : lo;
        else
            cp = 21'($urandom_range(hi, lo));
        if (cp >= 21'hD800 && cp <= 21'hDFFF)
            cp = $urandom_range(0, 1) ? 21'hD7FF : 21'hE000;
        return cp;
    endfunction

    task automatic append_point(logic [20:0] cp);
        if (cp < 21'h80)
            utf8_bytes.push_back(cp[7:0]);
        else if (cp < 21'h800)
        begin
            utf8_bytes.push_back({3'b110, cp[10:6]});
            utf8_bytes.push_back({2'b10, cp[5:0]});
        end
        else if (cp < 21'h10000)
        begin
            utf8_bytes.push_back({4'b1110, cp[15:12]});
            utf8_bytes.push_back({2'b10, cp[11:6]});
            utf8_bytes.push_back({2'b10, cp[5:0]});
        end
        else
        begin
            utf8_bytes.push_back({5'b11110, cp[20:18]});
            utf8_bytes.push_back({2'b10, cp[17:12]});
            utf8_bytes.push_back({2'b10, cp[11:6]});
            utf8_bytes.push_back({2'b10, cp[5:0]});
        end
    endtask

    task automatic append_broken();
        logic [7:0] lead;
        case ($urandom_range(0, 3))
            0:
            begin
                if ($urandom_range(0, 1))
                    utf8_bytes.push_back(8'($urandom_range(8'h80, 8'hC1)));
                else
                    utf8_bytes.push_back(8'($urandom_range(LEAD_MAX + 1, 8'hFF)));
            end
            1:
            begin
                // second byte outside the range its lead allows
                case ($urandom_range(0, 3))
                    0:
                    begin
                        utf8_bytes.push_back(LEAD_3B);
                        utf8_bytes.push_back(8'($urandom_range(8'h80, E0_MIN - 1)));
                    end
                    1:
                    begin
                        utf8_bytes.push_back(LEAD_ED);
                        utf8_bytes.push_back(8'($urandom_range(ED_MAX + 1, 8'hBF)));
                    end
                    2:
                    begin
                        utf8_bytes.push_back(LEAD_4B);
                        utf8_bytes.push_back(8'($urandom_range(8'h80, F0_MIN - 1)));
                    end
                    default:
                    begin
                        utf8_bytes.push_back(LEAD_MAX);
                        utf8_bytes.push_back(8'($urandom_range(F4_MAX + 1, 8'hBF)));
                    end
                endcase
                utf8_bytes.push_back(8'($urandom_range(8'h80, 8'hBF)));
            end
            2:
            begin
                lead = 8'($urandom_range(LEAD_MIN, LEAD_MAX));
                utf8_bytes.push_back(lead);
                if (lead >= LEAD_3B && $urandom_range(0, 1))
                    utf8_bytes.push_back(8'hA0 + 8'($urandom_range(0, 15)));
                if ($urandom_range(0, 1))
                    utf8_bytes.push_back(8'($urandom_range(8'h01, 8'h7F)));
                else
                    utf8_bytes.push_back(8'($urandom_range(8'hC0, 8'hFF)));
            end
            default:
            begin
                // zero inside a sequence ends the string
                utf8_bytes.push_back(8'($urandom_range(LEAD_MIN, LEAD_MAX)));
                utf8_bytes.push_back(8'h00);
            end
        endcase
    endtask

    task automatic build_string();
        int nchars;
        utf8_bytes.delete();
        if ($urandom_range(0, 99) < 8)
        begin
            repeat ($urandom_range(1, 12))
                utf8_bytes.push_back(8'($urandom_range(8'h01, 8'hFF)));
        end
        else
        begin
            nchars = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(0, 24);
            repeat (nchars)
            begin
                if ($urandom_range(0, 39) == 0)
                    append_broken();
                else
                    append_point(draw_point($urandom_range(0, 3)));
            end
        end
        utf8_bytes.push_back(8'h00);
    endtask

    // watchdog: ends the run after a long stretch with no beat on either side
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [7:0]  directed[24];
        logic [15:0] caps[NUM_PHASES];
        int          sent;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = 16'h0000;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_calm       = 1'b0;
        out_calm      = 1'b0;
        directed = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF, 8'h00,
                     8'hFF, 8'h00, 8'hE0, 8'h9F, 8'h00, 8'hF4, 8'h90, 8'h00,
                     8'hC2, 8'h00, 8'hF0, 8'h90, 8'h80, 8'h80, 8'h00};
        caps = '{16'd1, 16'd0, 16'd2, 16'd3, 16'd4, 16'd7,
                 16'($urandom_range(1, 16)), 16'hFFFF, 16'($urandom_range(0, 65535))};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_byte(directed[i]);

        foreach (caps[p])
        begin
            set_capacity(caps[p]);
            sent = 0;
            while (sent < PHASE_BYTES)
            begin
                build_string();
                send_string();
                sent += utf8_bytes.size();
                if ($urandom_range(0, 7) == 0)
                    in_calm = ~in_calm;
                if ($urandom_range(0, 7) == 0)
                    out_calm = ~out_calm;
            end
        end

        drain();
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
